FILE: sv/eta_pkg.sv
`default_nettype none
package eta_pkg;

    localparam int DEF_MAX_SAMPLES = 4096;
    localparam int DEF_MAX_BINS    = 63;
    localparam int FRAC_BITS       = 8;

    localparam int TIME_W  = 32;
    localparam int VAL_W   = 16;
    localparam int BIN_W   = 6;
    localparam int MEAN_W  = 24;
    localparam int VAR_W   = 40;
    localparam int MSUM_W  = 40;
    localparam int SSUM_W  = 56;
    localparam int EVC_W   = 16;
    localparam int DIV_W   = 64;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_W-1:0] BIN_WIDTH_RESET = 16'd10;
    localparam logic [BIN_W-1:0] BIN_COUNT_RESET = 6'd21;
    localparam logic [EVC_W-1:0] EVENT_CAP       = 16'hFFFF;

    localparam logic [CFG_IDX_W-1:0] CFG_BIN_WIDTH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BIN_COUNT = 1'd1;

    localparam logic [1:0] REQ_LOAD   = 2'd0;
    localparam logic [1:0] REQ_EVENT  = 2'd1;
    localparam logic [1:0] REQ_FINISH = 2'd2;

    typedef struct packed {
        logic [1:0]              req_type;
        logic [TIME_W-1:0]       time_stamp;
        logic signed [VAL_W-1:0] sample_value;
    } req_t;

    typedef struct packed {
        logic [BIN_W-1:0]         bin_index;
        logic signed [MEAN_W-1:0] bin_mean;
        logic [VAR_W-1:0]         bin_variance;
        logic                     bin_empty;
        logic                     store_overflow;
        logic                     last_bin;
    } res_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_EV_SETUP,
        ST_SW_READ,
        ST_SW_CHK,
        ST_SW_DIV,
        ST_SW_TRD,
        ST_SW_TUPD,
        ST_BN_READ,
        ST_BN_CHK,
        ST_BN_ST1,
        ST_BN_DIV1,
        ST_BN_ST2,
        ST_BN_DIV2,
        ST_BN_NEXT,
        ST_FN_READ,
        ST_FN_CHK,
        ST_FN_ST1,
        ST_FN_DIV1,
        ST_FN_ST2,
        ST_FN_DIV2,
        ST_FN_MUL,
        ST_FN_OUT
    } state_t;

endpackage
`default_nettype wire

FILE: sv/eta_div.sv
`default_nettype none
module eta_div
    import eta_pkg::*;
#(
    parameter int NUM_W = DIV_W,
    parameter int DEN_W = EVC_W
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    output logic                  done,
    output logic [NUM_W-1:0]      quo
);

    localparam int STEP_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0]  num_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [DEN_W-1:0]  rem_reg;
    logic [STEP_W-1:0] step_reg;
    logic              done_reg;

    logic [DEN_W:0]    r2;
    logic [DEN_W:0]    r2_sub;
    logic              ge;
    logic [DEN_W-1:0]  rem_next;

    always_comb
    begin
        r2       = {rem_reg, num_reg[NUM_W-1]};
        ge       = r2 >= {1'b0, den_reg};
        r2_sub   = r2 - {1'b0, den_reg};
        rem_next = ge ? r2_sub[DEN_W-1:0] : r2[DEN_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            step_reg <= STEP_W'(NUM_W);
            done_reg <= 1'b0;
        end
        else if (step_reg != '0)
        begin
            step_reg <= step_reg - 1'b1;
            done_reg <= (step_reg == STEP_W'(1));
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // round to nearest: bias the dividend by half the divisor
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= num + NUM_W'(den >> 1);
            den_reg <= den;
            rem_reg <= '0;
        end
        else if (step_reg != '0)
        begin
            num_reg <= {num_reg[NUM_W-2:0], ge};
            rem_reg <= rem_next;
        end
    end

    assign done = done_reg;
    assign quo  = num_reg;

endmodule
`default_nettype wire

FILE: sv/event_triggered_average_top.sv
`default_nettype none
// Event-triggered average. Load a word with req_type 0 to store a sample, 1 to
// fold an event into the per-bin accumulators, 2 to emit one result per active
// bin and clear everything. An event runs a setup step, then for each stored
// sample inside the window a 6-step bin search and a read-modify-write of the bin
// scratch memory (samples outside it are skipped), then two runs of the serial
// divider for each bin that received samples. A finish runs the divider twice per
// bin that has events; each result word appears for exactly one cycle with
// result_valid and must be taken then, the block never waits for it.
// busy is high while an event or finish is in progress.
module event_triggered_average_top
    import eta_pkg::*;
#(
    parameter int MAX_SAMPLES = DEF_MAX_SAMPLES,
    parameter int MAX_BINS    = DEF_MAX_BINS
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire req_t                 req,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    output logic                      result_valid,
    output res_t                      result
);

    localparam int AW     = $clog2(MAX_SAMPLES);
    localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
    localparam int BIN_AW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
    localparam int SUM_W  = VAL_W + CNT_W;
    localparam int SQ_W   = 2 * VAL_W - 1 + CNT_W;
    localparam int DEN_W  = (CNT_W > EVC_W) ? CNT_W : EVC_W;
    localparam int TOP_BINS = (MAX_BINS - 1) | 1;
    localparam int NW_W   = BIN_W + CFG_W;
    localparam int D_W    = TIME_W + 2;
    localparam int PROD_W = 2 * MEAN_W;
    localparam logic [PROD_W:0] HALF =
        (FRAC_BITS > 0) ? (PROD_W + 1)'(1) << (FRAC_BITS - 1) : '0;
    localparam logic signed [MSUM_W:0] MEAN_MAX = (MSUM_W + 1)'(8388607);
    localparam logic signed [MSUM_W:0] MEAN_MIN = -(MSUM_W + 1)'(8388608);

    // memories
    logic [TIME_W-1:0]       st_time_mem [MAX_SAMPLES];
    logic [VAL_W-1:0]        st_val_mem  [MAX_SAMPLES];
    logic [SUM_W-1:0]        tsum_mem    [MAX_BINS];
    logic [SQ_W-1:0]         tsq_mem     [MAX_BINS];
    logic [CNT_W-1:0]        tcnt_mem    [MAX_BINS];
    logic [MSUM_W-1:0]       ams_mem     [MAX_BINS];
    logic [SSUM_W-1:0]       ass_mem     [MAX_BINS];
    logic [EVC_W-1:0]        aev_mem     [MAX_BINS];

    logic [TIME_W-1:0]       st_time_q;
    logic [VAL_W-1:0]        st_val_q;
    logic [SUM_W-1:0]        tsum_q;
    logic [SQ_W-1:0]         tsq_q;
    logic [CNT_W-1:0]        tcnt_q;
    logic [MSUM_W-1:0]       ams_q;
    logic [SSUM_W-1:0]       ass_q;
    logic [EVC_W-1:0]        aev_q;

    // control and payload registers
    state_t                  state_reg, state_next;
    logic [CFG_W-1:0]        bin_width_reg;
    logic [BIN_W-1:0]        bin_count_reg;
    logic [CNT_W-1:0]        count_reg;
    logic                    dropped_reg;
    logic [CNT_W-1:0]        samp_reg;
    logic [BIN_W-1:0]        bin_reg;
    logic [BIN_W-1:0]        q_reg;
    logic [2:0]              step_reg;
    logic [MAX_BINS-1:0]     tvalid_reg;
    logic [MAX_BINS-1:0]     avalid_reg;
    logic                    res_valid_reg;

    logic [TIME_W-1:0]       ev_reg;
    logic signed [D_W-1:0]   lb_reg;
    logic [NW_W-1:0]         nw_reg;
    logic [NW_W-1:0]         d_reg;
    logic signed [VAL_W-1:0] val_reg;
    logic [SUM_W-1:0]        tmag_reg;
    logic [SQ_W-1:0]         tsq_reg;
    logic [CNT_W-1:0]        tcnt_reg;
    logic                    neg_reg;
    logic [MSUM_W-1:0]       ams_reg;
    logic [MSUM_W-1:0]       amag_reg;
    logic [SSUM_W-1:0]       ass_reg;
    logic [EVC_W-1:0]        aev_reg;
    logic [DIV_W-1:0]        mq_reg;
    logic [SSUM_W-1:0]       msq_reg;
    logic [PROD_W-1:0]       prod_reg;
    res_t                    res_reg;

    // combinational
    logic [BIN_W-1:0]        n_raw;
    logic [BIN_W-1:0]        n_act;
    logic                    last_of_run;
    logic signed [D_W-1:0]   d_cur;
    logic                    in_win;
    logic [NW_W-1:0]         trial;
    logic                    trial_ge;
    logic [SUM_W-1:0]        t_sum_cur;
    logic [SQ_W-1:0]         t_sq_cur;
    logic [CNT_W-1:0]        t_cnt_cur;
    logic [MSUM_W-1:0]       a_ms_cur;
    logic [SSUM_W-1:0]       a_ss_cur;
    logic [EVC_W-1:0]        a_ev_cur;
    logic                    bin_skip;

    logic [BIN_AW-1:0]       tmp_addr;
    logic                    tmp_we;
    logic                    acc_we;
    logic                    div_start;
    logic [DIV_W-1:0]        div_num;
    logic [DEN_W-1:0]        div_den;
    logic                    div_done;
    logic [DIV_W-1:0]        div_quo;

    logic                    load_ok;
    logic signed [SUM_W-1:0] v_ext;
    logic [SQ_W-1:0]         v_sq;
    logic [MSUM_W-1:0]       ev_mean;
    logic [MSUM_W-1:0]       new_ms;
    logic [SSUM_W-1:0]       new_ss;
    logic [EVC_W-1:0]        new_ev;
    logic [PROD_W:0]         sqm;
    logic [SSUM_W-1:0]       var_full;
    logic signed [MSUM_W:0]  mean_full;
    logic signed [MEAN_W-1:0] mean_sat;
    logic [VAR_W-1:0]        var_sat;

    eta_div #(
        .NUM_W (DIV_W),
        .DEN_W (DEN_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    always_comb
    begin
        n_raw       = bin_count_reg | BIN_W'(1);
        n_act       = (n_raw > BIN_W'(TOP_BINS)) ? BIN_W'(TOP_BINS) : n_raw;
        last_of_run = (bin_reg == n_act - 1'b1);

        d_cur  = $signed({2'b00, st_time_q}) - lb_reg;
        in_win = !d_cur[D_W-1] && (d_cur[D_W-2:0] < (D_W - 1)'(nw_reg));
        trial    = NW_W'(bin_width_reg) << step_reg;
        trial_ge = d_reg >= trial;

        t_sum_cur = tvalid_reg[bin_reg[BIN_AW-1:0]] ? tsum_q : '0;
        t_sq_cur  = tvalid_reg[bin_reg[BIN_AW-1:0]] ? tsq_q  : '0;
        t_cnt_cur = tvalid_reg[bin_reg[BIN_AW-1:0]] ? tcnt_q : '0;
        a_ms_cur  = avalid_reg[bin_reg[BIN_AW-1:0]] ? ams_q  : '0;
        a_ss_cur  = avalid_reg[bin_reg[BIN_AW-1:0]] ? ass_q  : '0;
        a_ev_cur  = avalid_reg[bin_reg[BIN_AW-1:0]] ? aev_q  : '0;
        bin_skip  = (t_cnt_cur == '0) || (a_ev_cur >= EVENT_CAP);

        load_ok = count_reg < CNT_W'(MAX_SAMPLES);

        v_ext = SUM_W'(val_reg);
        v_sq  = SQ_W'(unsigned'(32'(val_reg * val_reg)));

        ev_mean = neg_reg ? MSUM_W'(-mq_reg) : mq_reg[MSUM_W-1:0];
        new_ms  = ams_reg + ev_mean;
        new_ss  = ass_reg + div_quo[SSUM_W-1:0];
        new_ev  = aev_reg + 1'b1;

        sqm       = ((PROD_W + 1)'(prod_reg) + HALF) >> FRAC_BITS;
        var_full  = (msq_reg > SSUM_W'(sqm)) ? msq_reg - SSUM_W'(sqm) : '0;
        var_sat   = (var_full > SSUM_W'({VAR_W{1'b1}})) ? {VAR_W{1'b1}}
                                                         : var_full[VAR_W-1:0];
        mean_full = neg_reg ? -$signed({1'b0, mq_reg[MSUM_W-1:0]})
                            :  $signed({1'b0, mq_reg[MSUM_W-1:0]});
        if (mean_full > MEAN_MAX)
            mean_sat = MEAN_MAX[MEAN_W-1:0];
        else if (mean_full < MEAN_MIN)
            mean_sat = MEAN_MIN[MEAN_W-1:0];
        else
            mean_sat = mean_full[MEAN_W-1:0];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    case (req.req_type)
                        REQ_EVENT:  state_next = ST_EV_SETUP;
                        REQ_FINISH: state_next = ST_FN_READ;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_EV_SETUP: state_next = ST_SW_READ;
            ST_SW_READ:  state_next = (samp_reg == count_reg) ? ST_BN_READ : ST_SW_CHK;
            ST_SW_CHK:   state_next = in_win ? ST_SW_DIV : ST_SW_READ;
            ST_SW_DIV:   state_next = (step_reg == '0) ? ST_SW_TRD : ST_SW_DIV;
            ST_SW_TRD:   state_next = ST_SW_TUPD;
            ST_SW_TUPD:  state_next = ST_SW_READ;
            ST_BN_READ:  state_next = ST_BN_CHK;
            ST_BN_CHK:   state_next = bin_skip ? ST_BN_NEXT : ST_BN_ST1;
            ST_BN_ST1:   state_next = ST_BN_DIV1;
            ST_BN_DIV1:  state_next = div_done ? ST_BN_ST2 : ST_BN_DIV1;
            ST_BN_ST2:   state_next = ST_BN_DIV2;
            ST_BN_DIV2:  state_next = div_done ? ST_BN_NEXT : ST_BN_DIV2;
            ST_BN_NEXT:  state_next = last_of_run ? ST_IDLE : ST_BN_READ;
            ST_FN_READ:  state_next = ST_FN_CHK;
            ST_FN_CHK:   state_next = (a_ev_cur == '0) ? ST_FN_OUT : ST_FN_ST1;
            ST_FN_ST1:   state_next = ST_FN_DIV1;
            ST_FN_DIV1:  state_next = div_done ? ST_FN_ST2 : ST_FN_DIV1;
            ST_FN_ST2:   state_next = ST_FN_DIV2;
            ST_FN_DIV2:  state_next = div_done ? ST_FN_MUL : ST_FN_DIV2;
            ST_FN_MUL:   state_next = ST_FN_OUT;
            ST_FN_OUT:   state_next = last_of_run ? ST_IDLE : ST_FN_READ;
            default:     state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        tmp_addr  = bin_reg[BIN_AW-1:0];
        tmp_we    = 1'b0;
        acc_we    = 1'b0;
        div_start = 1'b0;
        div_num   = '0;
        div_den   = DEN_W'(tcnt_reg);
        case (state_reg)
            ST_SW_TRD:
            begin
                tmp_addr = q_reg[BIN_AW-1:0];
            end
            ST_SW_TUPD:
            begin
                tmp_addr = q_reg[BIN_AW-1:0];
                tmp_we   = 1'b1;
            end
            ST_BN_ST1:
            begin
                div_start = 1'b1;
                div_num   = DIV_W'(tmag_reg) << FRAC_BITS;
            end
            ST_BN_ST2:
            begin
                div_start = 1'b1;
                div_num   = DIV_W'(tsq_reg) << FRAC_BITS;
            end
            ST_BN_DIV2:
            begin
                acc_we = div_done;
            end
            ST_FN_ST1:
            begin
                div_start = 1'b1;
                div_num   = DIV_W'(amag_reg);
                div_den   = DEN_W'(aev_reg);
            end
            ST_FN_ST2:
            begin
                div_start = 1'b1;
                div_num   = DIV_W'(ass_reg);
                div_den   = DEN_W'(aev_reg);
            end
            default:
            begin
                tmp_we = 1'b0;
            end
        endcase
    end

    // sample store
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && start && req.req_type == REQ_LOAD && load_ok)
        begin
            st_time_mem[count_reg[AW-1:0]] <= req.time_stamp;
            st_val_mem[count_reg[AW-1:0]]  <= req.sample_value;
        end
        st_time_q <= st_time_mem[samp_reg[AW-1:0]];
        st_val_q  <= st_val_mem[samp_reg[AW-1:0]];
    end

    // per-event bin scratch
    always_ff @(posedge clk)
    begin
        if (tmp_we)
        begin
            tsum_mem[tmp_addr] <= (tvalid_reg[tmp_addr] ? tsum_q : '0) + SUM_W'(v_ext);
            tsq_mem[tmp_addr]  <= (tvalid_reg[tmp_addr] ? tsq_q : '0) + v_sq;
            tcnt_mem[tmp_addr] <= (tvalid_reg[tmp_addr] ? tcnt_q : '0) + 1'b1;
        end
        tsum_q <= tsum_mem[tmp_addr];
        tsq_q  <= tsq_mem[tmp_addr];
        tcnt_q <= tcnt_mem[tmp_addr];
    end

    // accumulators across events
    always_ff @(posedge clk)
    begin
        if (acc_we)
        begin
            ams_mem[bin_reg[BIN_AW-1:0]] <= new_ms;
            ass_mem[bin_reg[BIN_AW-1:0]] <= new_ss;
            aev_mem[bin_reg[BIN_AW-1:0]] <= new_ev;
        end
        ams_q <= ams_mem[bin_reg[BIN_AW-1:0]];
        ass_q <= ass_mem[bin_reg[BIN_AW-1:0]];
        aev_q <= aev_mem[bin_reg[BIN_AW-1:0]];
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            bin_width_reg <= BIN_WIDTH_RESET;
            bin_count_reg <= BIN_COUNT_RESET;
            count_reg     <= '0;
            dropped_reg   <= 1'b0;
            samp_reg      <= '0;
            bin_reg       <= '0;
            q_reg         <= '0;
            step_reg      <= '0;
            tvalid_reg    <= '0;
            avalid_reg    <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= (state_reg == ST_FN_OUT);

            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_BIN_WIDTH: bin_width_reg <= cfg_data;
                    CFG_BIN_COUNT: bin_count_reg <= cfg_data[BIN_W-1:0];
                    default:       bin_width_reg <= bin_width_reg;
                endcase
            end

            case (state_reg)
                ST_IDLE:
                begin
                    samp_reg   <= '0;
                    bin_reg    <= '0;
                    tvalid_reg <= '0;
                    if (start && req.req_type == REQ_LOAD)
                    begin
                        if (load_ok)
                            count_reg <= count_reg + 1'b1;
                        else
                            dropped_reg <= 1'b1;
                    end
                end
                ST_SW_READ:
                begin
                    bin_reg <= '0;
                end
                ST_SW_CHK:
                begin
                    q_reg    <= '0;
                    step_reg <= 3'd5;
                    if (!in_win)
                        samp_reg <= samp_reg + 1'b1;
                end
                ST_SW_DIV:
                begin
                    if (trial_ge)
                        q_reg[step_reg] <= 1'b1;
                    if (step_reg != '0)
                        step_reg <= step_reg - 1'b1;
                end
                ST_SW_TUPD:
                begin
                    tvalid_reg[q_reg[BIN_AW-1:0]] <= 1'b1;
                    samp_reg <= samp_reg + 1'b1;
                end
                ST_BN_DIV2:
                begin
                    if (div_done)
                        avalid_reg[bin_reg[BIN_AW-1:0]] <= 1'b1;
                end
                ST_BN_NEXT:
                begin
                    if (!last_of_run)
                        bin_reg <= bin_reg + 1'b1;
                end
                ST_FN_OUT:
                begin
                    if (last_of_run)
                    begin
                        avalid_reg  <= '0;
                        count_reg   <= '0;
                        dropped_reg <= 1'b0;
                    end
                    else
                    begin
                        bin_reg <= bin_reg + 1'b1;
                    end
                end
                default:
                begin
                    step_reg <= step_reg;
                end
            endcase
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                ev_reg <= req.time_stamp;
            end
            ST_EV_SETUP:
            begin
                lb_reg <= $signed({2'b00, ev_reg})
                        - $signed(D_W'(NW_W'((n_act - 1'b1) >> 1) * NW_W'(bin_width_reg)));
                nw_reg <= NW_W'(n_act) * NW_W'(bin_width_reg);
            end
            ST_SW_CHK:
            begin
                d_reg   <= d_cur[NW_W-1:0];
                val_reg <= st_val_q;
            end
            ST_SW_DIV:
            begin
                if (trial_ge)
                    d_reg <= d_reg - trial;
            end
            ST_BN_CHK:
            begin
                neg_reg  <= t_sum_cur[SUM_W-1];
                tmag_reg <= t_sum_cur[SUM_W-1] ? SUM_W'(-t_sum_cur) : t_sum_cur;
                tsq_reg  <= t_sq_cur;
                tcnt_reg <= t_cnt_cur;
                ams_reg  <= a_ms_cur;
                ass_reg  <= a_ss_cur;
                aev_reg  <= a_ev_cur;
            end
            ST_BN_DIV1:
            begin
                if (div_done)
                    mq_reg <= div_quo;
            end
            ST_FN_CHK:
            begin
                neg_reg  <= a_ms_cur[MSUM_W-1];
                amag_reg <= a_ms_cur[MSUM_W-1] ? MSUM_W'(-a_ms_cur) : a_ms_cur;
                ass_reg  <= a_ss_cur;
                aev_reg  <= a_ev_cur;
            end
            ST_FN_DIV1:
            begin
                if (div_done)
                    mq_reg <= div_quo;
            end
            ST_FN_DIV2:
            begin
                if (div_done)
                    msq_reg <= div_quo[SSUM_W-1:0];
            end
            ST_FN_MUL:
            begin
                prod_reg <= mq_reg[MEAN_W-1:0] * mq_reg[MEAN_W-1:0];
            end
            ST_FN_OUT:
            begin
                res_reg.bin_index      <= bin_reg;
                res_reg.bin_empty      <= (aev_reg == '0);
                res_reg.store_overflow <= dropped_reg;
                res_reg.last_bin       <= last_of_run;
                if (aev_reg == '0)
                begin
                    res_reg.bin_mean     <= '0;
                    res_reg.bin_variance <= '0;
                end
                else
                begin
                    res_reg.bin_mean     <= mean_sat;
                    res_reg.bin_variance <= var_sat;
                end
            end
            default:
            begin
                ev_reg <= ev_reg;
            end
        endcase
    end

    assign busy         = (state_reg != ST_IDLE);
    assign result_valid = res_valid_reg;
    assign result       = res_reg;

endmodule
`default_nettype wire

FILE: test/event_triggered_average_top_test.sv
module event_triggered_average_top_test;
    import eta_pkg::*;

    localparam int  NBINS      = 63;
    localparam int  STORE_SIZE = 4096;
    localparam longint CYCLE_LIMIT = 20000000;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    req_t                 req;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 result_valid;
    res_t                 result;

    event_triggered_average_top dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .req(req),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .result_valid(result_valid), .result(result)
    );

    // predictor state
    logic [31:0]        smp_time[$];
    logic signed [15:0] smp_val[$];
    longint             mean_acc[NBINS];
    longint unsigned    square_acc[NBINS];
    int unsigned        hit_events[NBINS];
    bit                 overflowed;
    logic [15:0]        width_reg;
    logic [5:0]         count_reg;

    res_t   bin_results_due[$];
    int     errors;
    int     sent;
    bit     gaps_on;
    longint cycles;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("event_triggered_average_top regression: fail");
            $finish;
        end
    end

    function automatic longint round_div(longint num, longint unsigned den);
        longint unsigned mag;
        longint unsigned q;
        mag = (num < 0) ? longint'(-num) : num;
        q = (mag + den / 2) / den;
        return (num < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic int unsigned bins_in_use();
        return int'(count_reg | 6'd1);
    endfunction

    function automatic void clear_store();
        smp_time.delete();
        smp_val.delete();
        for (int j = 0; j < NBINS; j++)
        begin
            mean_acc[j] = 0;
            square_acc[j] = 0;
            hit_events[j] = 0;
        end
        overflowed = 0;
    endfunction

    function automatic void fold_event(logic [31:0] ev);
        longint          sum[NBINS];
        longint unsigned sq[NBINS];
        int unsigned     cnt[NBINS];
        int unsigned     n;
        longint          w;
        longint          lb;
        longint          d;
        longint          v;
        int unsigned     j;
        n = bins_in_use();
        w = longint'(width_reg);
        lb = longint'({32'd0, ev}) - longint'((n - 1) / 2) * w;
        for (int k = 0; k < NBINS; k++)
        begin
            sum[k] = 0;
            sq[k] = 0;
            cnt[k] = 0;
        end
        if (w == 0)
            return;
        for (int i = 0; i < smp_time.size(); i++)
        begin
            d = longint'({32'd0, smp_time[i]}) - lb;
            v = longint'(smp_val[i]);
            if (d < 0 || d / w >= n)
                continue;
            j = int'(d / w);
            sum[j] += v;
            sq[j] += longint'(v * v);
            cnt[j]++;
        end
        for (int k = 0; k < n; k++)
        begin
            if (cnt[k] == 0 || hit_events[k] >= 65535)
                continue;
            hit_events[k]++;
            mean_acc[k] += round_div(sum[k] * 256, cnt[k]);
            square_acc[k] += longint'(round_div(longint'(sq[k] << FRAC_BITS), cnt[k]));
        end
    endfunction

    function automatic void emit_bins();
        int unsigned     n;
        longint          mean;
        longint          msq;
        longint unsigned mag;
        longint unsigned sqm;
        longint unsigned var_v;
        res_t            r;
        n = bins_in_use();
        for (int j = 0; j < n; j++)
        begin
            mean = 0;
            var_v = 0;
            if (hit_events[j] > 0)
            begin
                msq = round_div(longint'(square_acc[j]), hit_events[j]);
                mean = round_div(mean_acc[j], hit_events[j]);
                mag = (mean < 0) ? longint'(-mean) : mean;
                sqm = (mag * mag + 128) >> FRAC_BITS;
                var_v = (longint'(msq) > sqm) ? longint'(msq) - sqm : 0;
                if (var_v > 64'hFF_FFFF_FFFF)
                    var_v = 64'hFF_FFFF_FFFF;
                if (mean > 8388607)
                    mean = 8388607;
                if (mean < -8388608)
                    mean = -8388608;
            end
            r.bin_index = j[5:0];
            r.bin_mean = mean[23:0];
            r.bin_variance = var_v[39:0];
            r.bin_empty = (hit_events[j] == 0);
            r.store_overflow = overflowed;
            r.last_bin = (j + 1 == n);
            bin_results_due.push_back(r);
        end
        clear_store();
    endfunction

    function automatic void predict(req_t r);
        case (r.req_type)
            REQ_LOAD:
            begin
                if (smp_time.size() < STORE_SIZE)
                begin
                    smp_time.push_back(r.time_stamp);
                    smp_val.push_back(r.sample_value);
                end
                else
                    overflowed = 1;
            end
            REQ_EVENT:  fold_event(r.time_stamp);
            REQ_FINISH: emit_bins();
            default: ;
        endcase
    endfunction

    // result checker: results cannot be held off, take each as it comes
    always @(posedge clk)
    begin
        res_t e;
        if (rst_n && result_valid)
        begin
            if (bin_results_due.size() == 0)
            begin
                $error("unexpected bin result index %0d", result.bin_index);
                errors++;
            end
            else
            begin
                e = bin_results_due.pop_front();
                if (result.bin_index !== e.bin_index)
                begin
                    $error("bin_index exp %0d got %0d", e.bin_index, result.bin_index);
                    errors++;
                end
                if (result.bin_mean !== e.bin_mean)
                begin
                    $error("bin_mean exp %0d got %0d", e.bin_mean, result.bin_mean);
                    errors++;
                end
                if (result.bin_variance !== e.bin_variance)
                begin
                    $error("bin_variance exp %0d got %0d", e.bin_variance,
                           result.bin_variance);
                    errors++;
                end
                if (result.bin_empty !== e.bin_empty)
                begin
                    $error("bin_empty exp %0b got %0b", e.bin_empty, result.bin_empty);
                    errors++;
                end
                if (result.store_overflow !== e.store_overflow)
                begin
                    $error("store_overflow exp %0b got %0b", e.store_overflow,
                           result.store_overflow);
                    errors++;
                end
                if (result.last_bin !== e.last_bin)
                begin
                    $error("last_bin exp %0b got %0b", e.last_bin, result.last_bin);
                    errors++;
                end
            end
        end
    end

    // call at a rising edge; returns at a rising edge
    task automatic send_word(logic [1:0] kind, logic [31:0] ts, logic [15:0] value);
        req_t r;
        int   gap;
        r.req_type = kind;
        r.time_stamp = ts;
        r.sample_value = value;
        start <= 1'b1;
        req <= r;
        @(negedge clk);
        while (busy)
            @(negedge clk);
        @(posedge clk);
        predict(r);
        if (kind != 2'd3)
            sent++;
        gap = 0;
        if (gaps_on)
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        @(posedge clk);
        while (bin_results_due.size() != 0 || busy)
            @(posedge clk);
        // let the block settle back to idle after the last bin
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_BIN_WIDTH)
            width_reg = data;
        else
            count_reg = data[5:0];
    endtask

    task automatic set_bins(logic [15:0] w, logic [5:0] c);
        wait_idle();
        write_reg(CFG_BIN_WIDTH, w);
        write_reg(CFG_BIN_COUNT, {10'd0, c});
    endtask

    task automatic test_reset_settings();
        send_word(REQ_LOAD, 32'd95, 16'sd100);
        send_word(REQ_LOAD, 32'd100, -16'sd50);
        send_word(REQ_LOAD, 32'd104, 16'sd7);
        send_word(REQ_LOAD, 32'd130, 16'sd300);
        send_word(REQ_EVENT, 32'd100, 16'd0);
        send_word(REQ_EVENT, 32'd120, 16'd0);
        send_word(REQ_FINISH, 32'd0, 16'd0);
    endtask

    task automatic test_field_extremes();
        set_bins(16'hFFFF, 6'd63);
        send_word(REQ_LOAD, 32'd0, 16'h8000);
        send_word(REQ_LOAD, 32'd1, 16'h7FFF);
        send_word(REQ_LOAD, 32'hFFFF_FFFF, 16'h7FFF);
        // out of order sample still counts
        send_word(REQ_LOAD, 32'd5, 16'hFFFF);
        send_word(REQ_EVENT, 32'd0, 16'd0);
        send_word(REQ_EVENT, 32'hFFFF_FFFF, 16'd0);
        send_word(2'd3, 32'hFFFF_FFFF, 16'hFFFF);
        send_word(REQ_FINISH, 32'hFFFF_FFFF, 16'hFFFF);
        // even count rounds up, zero becomes one bin
        set_bins(16'd1, 6'd0);
        send_word(REQ_LOAD, 32'd7, 16'h8000);
        send_word(REQ_LOAD, 32'd7, 16'h8000);
        send_word(REQ_EVENT, 32'd7, 16'd0);
        send_word(REQ_FINISH, 32'd0, 16'd0);
        set_bins(16'd0, 6'd20);
        send_word(REQ_LOAD, 32'd7, 16'd3);
        send_word(REQ_EVENT, 32'd7, 16'd0);
        send_word(REQ_FINISH, 32'd0, 16'd0);
        set_bins(16'd3, 6'd62);
        send_word(REQ_FINISH, 32'd0, 16'd0);
    endtask

    task automatic test_random_runs();
        logic [15:0] w;
        logic [5:0]  c;
        logic [31:0] t;
        logic [31:0] times[$];
        int          k;
        int          span;
        while (sent < 410)
        begin
            case ($urandom_range(0, 5))
                0:       w = 16'hFFFF;
                1:       w = 16'd1;
                2:       w = $urandom;
                default: w = $urandom_range(1, 40);
            endcase
            c = ($urandom_range(0, 4) == 0) ? 6'd63 : 6'($urandom_range(0, 11));
            if ($urandom_range(0, 19) == 0)
                w = 16'd0;
            set_bins(w, c);
            gaps_on = ($urandom_range(0, 3) != 0);
            times.delete();
            t = $urandom;
            k = $urandom_range(0, 12);
            for (int i = 0; i < k; i++)
            begin
                t = t + $urandom_range(0, 2 * int'(w) + 1);
                times.push_back(t);
                send_word(REQ_LOAD, t, $urandom);
            end
            span = int'(c | 6'd1) * int'(w);
            repeat ($urandom_range(1, 5))
            begin
                case ($urandom_range(0, 9))
                    0:       send_word(REQ_EVENT, $urandom, $urandom);
                    1:       send_word(2'd3, $urandom, $urandom);
                    2:       send_word(REQ_LOAD, $urandom, $urandom);
                    default:
                    begin
                        t = (times.size() > 0) ? times[$urandom_range(0, times.size() - 1)]
                                               : $urandom;
                        t = t + $urandom_range(0, span) - span / 2;
                        send_word(REQ_EVENT, t, $urandom);
                    end
                endcase
            end
            send_word(REQ_FINISH, $urandom, $urandom);
        end
    endtask

    initial
    begin
        errors = 0;
        sent = 0;
        cycles = 0;
        gaps_on = 1;
        rst_n = 1'b0;
        start = 1'b0;
        req = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        width_reg = BIN_WIDTH_RESET;
        count_reg = BIN_COUNT_RESET;
        clear_store();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_settings();
        test_field_extremes();
        test_random_runs();
        wait_idle();
        repeat (200) @(posedge clk);
        if (errors == 0 && bin_results_due.size() == 0)
            $display("event_triggered_average_top regression: pass");
        else
            $display("event_triggered_average_top regression: fail");
        $finish;
    end

endmodule
